[hdl/dmvm_pkg.sv]
// ----------------------------------------------------------------------------
// Diagonal majority vote merger package
// Shared constants, the merge mode type and the window bit select helper.
// ----------------------------------------------------------------------------
`default_nettype none

package dmvm_pkg;

  localparam int SEQ_LEN_DEFAULT = 16;
  localparam int WIN_W           = 16;
  localparam int WIN_IDX_W       = $clog2(WIN_W);
  localparam int IDX_W           = 7;
  localparam int MODE_W          = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_MAJORITY       = 2'd0,
    MODE_FIRST          = 2'd1,
    MODE_LAST           = 2'd2,
    MODE_LAST_PER_FRAME = 2'd3
  } merge_mode_t;

  // Bits above the top of the window read as zero.
  function automatic logic vote_bit(input logic [WIN_W-1:0] win,
                                    input logic [IDX_W-1:0] j);
    logic result;
    result = 1'b0;
    if (j < IDX_W'(WIN_W)) begin
      result = win[j[WIN_IDX_W-1:0]];
    end
    return result;
  endfunction

endpackage

`default_nettype wire

[hdl/dmvm_lane.sv]
// ----------------------------------------------------------------------------
// Diagonal vote lane
// Holds one running vote sum and shifts it one frame closer on each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dmvm_lane #(
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             clear,
  input  wire logic [CNT_W-1:0] upstream,
  input  wire logic             vote,
  output logic      [CNT_W-1:0] sum
);

  logic [CNT_W-1:0] sum_next;

  always_comb begin
    sum_next = (clear ? '0 : upstream) + CNT_W'(vote);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (en) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

[hdl/dmvm_merge.sv]
// ----------------------------------------------------------------------------
// Decision merge stage
// Combines the lane sum, window bits and delayed last bit under the merge mode.
// ----------------------------------------------------------------------------
`default_nettype none

module dmvm_merge
  import dmvm_pkg::*;
#(
  parameter int SEQ_LEN = SEQ_LEN_DEFAULT,
  parameter int CNT_W   = $clog2(SEQ_LEN + 1)
) (
  input  wire logic             [WIN_W-1:0] win,
  input  wire logic             [WIN_W-1:0] first_win,
  input  wire logic             [CNT_W-1:0] frame_idx,
  input  wire logic             [CNT_W-1:0] pending,
  input  wire logic                         last_now,
  input  wire logic                         delayed,
  input  wire merge_mode_t                  mode,
  output logic                              decision
);

  logic [CNT_W:0] sum;
  logic [CNT_W:0] count;
  logic [CNT_W:0] idx_inc;
  logic           early;

  always_comb begin
    sum     = {1'b0, pending} + (CNT_W + 1)'(win[0]);
    idx_inc = {1'b0, frame_idx} + 1'b1;
    early   = idx_inc < (CNT_W + 1)'(SEQ_LEN);
    count   = early ? idx_inc : (CNT_W + 1)'(SEQ_LEN);
    case (mode)
      MODE_MAJORITY: begin
        decision = {sum, 1'b0} > {1'b0, count};
      end
      MODE_FIRST: begin
        decision = win[0];
      end
      MODE_LAST: begin
        decision = last_now;
      end
      MODE_LAST_PER_FRAME: begin
        decision = early ? vote_bit(first_win, IDX_W'(frame_idx)) : delayed;
      end
      default: begin
        decision = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/diagonal_majority_vote_merger_unit.sv]
// ----------------------------------------------------------------------------
// Diagonal majority vote merger
// A decision is valid in the cycle after its window transaction. Throughput:
// one window per cycle; the output register lets a new window in while it is
// taken or empty. Reset is synchronous and clears all vote state, the frame
// count and the stored first window; the merge mode returns to majority.
// ----------------------------------------------------------------------------
`default_nettype none

module diagonal_majority_vote_merger_unit
  import dmvm_pkg::*;
#(
  parameter int SEQ_LEN = SEQ_LEN_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             merge_mode_we,
  input  wire logic [MODE_W-1:0] merge_mode,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIN_W-1:0] window_votes,
  input  wire logic             first_of_video,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  frame_decision
);

  localparam int CNT_W = $clog2(SEQ_LEN + 1);
  localparam int LANES = (SEQ_LEN > 1) ? SEQ_LEN - 1 : 1;

  merge_mode_t      mode;
  logic             accept;
  logic             clear;
  logic [CNT_W-1:0] frames_seen;
  logic [CNT_W-1:0] frames_seen_next;
  logic [CNT_W-1:0] frame_idx;
  logic [WIN_W-1:0] first_window;
  logic [WIN_W-1:0] first_win;
  logic [LANES-1:0] last_bit_delay;
  logic [LANES-1:0] last_bit_delay_next;
  logic [CNT_W-1:0] lane_sum [LANES];
  logic [CNT_W-1:0] pending;
  logic             last_now;
  logic             delayed;
  logic             decision;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign clear    = first_of_video;

  assign frame_idx = clear ? '0 : frames_seen;
  assign first_win = clear ? window_votes : first_window;
  assign pending   = clear ? '0 : lane_sum[0];
  assign last_now  = vote_bit(window_votes, IDX_W'(SEQ_LEN - 1));
  assign delayed   = (SEQ_LEN >= 2) ? (!clear && last_bit_delay[LANES-1]) : last_now;

  assign frames_seen_next = (frame_idx < CNT_W'(SEQ_LEN)) ? frame_idx + 1'b1 : frame_idx;

  if (LANES > 1) begin : g_delay_line
    assign last_bit_delay_next = {(clear ? {(LANES - 1){1'b0}} : last_bit_delay[LANES-2:0]),
                                  last_now};
  end else begin : g_delay_bit
    assign last_bit_delay_next = last_now;
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [CNT_W-1:0] upstream;
    logic             vote;
    if (k + 1 < LANES) begin : g_mid
      assign upstream = lane_sum[k+1];
    end else begin : g_end
      assign upstream = '0;
    end
    assign vote = (k + 1 < SEQ_LEN) ? vote_bit(window_votes, IDX_W'(k + 1)) : 1'b0;
    dmvm_lane #(
      .CNT_W(CNT_W)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .en      (accept),
      .clear   (clear),
      .upstream(upstream),
      .vote    (vote),
      .sum     (lane_sum[k])
    );
  end

  dmvm_merge #(
    .SEQ_LEN(SEQ_LEN),
    .CNT_W  (CNT_W)
  ) u_merge (
    .win      (window_votes),
    .first_win(first_win),
    .frame_idx(frame_idx),
    .pending  (pending),
    .last_now (last_now),
    .delayed  (delayed),
    .mode     (mode),
    .decision (decision)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MAJORITY;
    end else if (merge_mode_we) begin
      mode <= merge_mode_t'(merge_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen    <= '0;
      first_window   <= '0;
      last_bit_delay <= '0;
    end else if (accept) begin
      frames_seen    <= frames_seen_next;
      first_window   <= first_win;
      last_bit_delay <= last_bit_delay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_decision <= decision;
    end
  end

endmodule

`default_nettype wire
